// File: rtl/mp4_chunk_offset_patcher_core_defines.svh
// Assertion macros used by the checker file.
`ifndef MP4_CHUNK_OFFSET_PATCHER_CORE_DEFINES_SVH
`define MP4_CHUNK_OFFSET_PATCHER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MP4COP_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("mp4cop assertion failed");

// Next-cycle implication, disabled during reset.
`define MP4COP_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("mp4cop assertion failed");

`endif

// File: rtl/mp4cop_pkg.sv
package mp4cop_pkg;

    localparam logic [31:0] TYPE_STCO = 32'h7374636F;
    localparam logic [31:0] TYPE_CO64 = 32'h636F3634;
    localparam logic [31:0] TYPE_CMOV = 32'h636D6F76;

    localparam logic [3:0]  HEADER_BYTES  = 4'd8;
    localparam logic [31:0] CMOV_POSITION = 32'd15;
    localparam logic [31:0] MIN_ATOM_SIZE = 32'd16;

    localparam int QUEUE_DEPTH = 4;
    localparam int BURST_MAX   = 8;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_COMPRESSED = 2'd1;
    localparam logic [1:0] ERR_ATOM_OVER  = 2'd2;
    localparam logic [1:0] ERR_TABLE_OVER = 2'd3;

    typedef enum logic [1:0] {
        MODE_SCAN,
        MODE_HEADER,
        MODE_ENTRIES
    } mode_t;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [3:0]                count;
        logic [1:0]                err;
    } burst_t;

    typedef struct packed {
        logic   valid;
        burst_t burst;
    } push_t;

endpackage

// File: rtl/mp4_chunk_offset_patcher_core.sv
// Channel  | Handshake                | Payload
// ---------+--------------------------+-------------------------------------
// in       | in_valid / in_ready      | data_byte, first_byte
// out      | out_valid / out_ready    | out_byte, run_end, error_code
// cfg      | cfg_write_en             | cfg_write_data (index length)
//
// One input byte is taken per cycle while the burst queue has a free slot.
// Each transfer yields a burst of 0 to 8 bytes, queued and sent one byte per cycle.
// The output port sets the sustained rate: one output byte per cycle.
// A full queue drops in_ready; a stalled output holds its byte.
// Reset clears all scan state, the sticky error and the index length.
module mp4_chunk_offset_patcher_core #(
    parameter int QUEUE_DEPTH = mp4cop_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        run_end,
    output logic [1:0]  error_code,
    input  logic        cfg_write_en,
    input  logic [31:0] cfg_write_data
);

    logic              accept;
    mp4cop_pkg::push_t push;

    assign accept = in_valid && in_ready;

    mp4cop_step u_step (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (data_byte),
        .first_byte     (first_byte),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .push           (push)
    );

    mp4cop_burst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space      (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_end    (run_end),
        .error_code (error_code)
    );

endmodule

// File: rtl/mp4cop_step.sv
module mp4cop_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 first_byte,
    input  logic                 cfg_write_en,
    input  logic [31:0]          cfg_write_data,
    output mp4cop_pkg::push_t    push
);

    logic [31:0]        len_reg;
    logic [31:0]        pos_reg, pos_next;
    logic [63:0]        recent_reg, recent_next;
    mp4cop_pkg::mode_t  mode_reg, mode_next;
    logic               wide_reg, wide_next;
    logic [31:0]        atom_end_reg, atom_end_next;
    logic [31:0]        left_reg, left_next;
    logic [63:0]        acc_reg, acc_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [1:0]         err_reg, err_next;

    logic [31:0]        cur_pos;
    logic [63:0]        cur_recent;
    mp4cop_pkg::mode_t  cur_mode;
    logic               cur_wide;
    logic [31:0]        cur_atom_end;
    logic [31:0]        cur_left;
    logic [63:0]        cur_acc;
    logic [3:0]         cur_cnt;

    logic               pass;
    logic               complete;
    logic [63:0]        acc_gather;
    logic [3:0]         cnt_gather;
    logic [3:0]         entry_width;
    logic [63:0]        patched;
    logic [3:0]         cnt_dec;
    logic [31:0]        table_count;
    logic [36:0]        table_span;
    logic [36:0]        table_end;
    logic [31:0]        box_size;
    logic [31:0]        atom_start;
    logic               type_hit;
    logic               match_ok;
    logic [3:0]         flush_cnt;
    logic [2:0]         sel;
    mp4cop_pkg::burst_t burst;

    always_comb
    begin
        if (first_byte)
        begin
            cur_pos      = '0;
            cur_recent   = '0;
            cur_mode     = mp4cop_pkg::MODE_SCAN;
            cur_wide     = 1'b0;
            cur_atom_end = '0;
            cur_left     = '0;
            cur_acc      = '0;
            cur_cnt      = '0;
        end
        else
        begin
            cur_pos      = pos_reg;
            cur_recent   = recent_reg;
            cur_mode     = mode_reg;
            cur_wide     = wide_reg;
            cur_atom_end = atom_end_reg;
            cur_left     = left_reg;
            cur_acc      = acc_reg;
            cur_cnt      = cnt_reg;
        end
    end

    always_comb
    begin
        recent_next   = {cur_recent[55:0], data_byte};
        pos_next      = (cur_pos == '1) ? cur_pos : cur_pos + 32'd1;
        mode_next     = cur_mode;
        wide_next     = cur_wide;
        atom_end_next = cur_atom_end;
        left_next     = cur_left;
        acc_next      = cur_acc;
        cnt_next      = cur_cnt;
        err_next      = err_reg;
        pass          = 1'b0;
        complete      = 1'b0;
        entry_width   = cur_wide ? 4'd8 : 4'd4;
        acc_gather    = {cur_acc[55:0], data_byte};
        cnt_gather    = cur_cnt + 4'd1;
        patched       = acc_gather + {32'd0, len_reg};
        if (!cur_wide)
        begin
            patched[63:32] = '0;
        end
        cnt_dec       = (cur_cnt != 4'd0) ? cur_cnt - 4'd1 : 4'd0;
        table_count   = recent_next[31:0];
        table_span    = cur_wide ? {2'd0, table_count, 3'd0} : {3'd0, table_count, 2'd0};
        table_end     = {5'd0, cur_pos} + 37'd1 + table_span;
        box_size      = recent_next[63:32];
        atom_start    = cur_pos - 32'd7;
        type_hit      = (recent_next[31:0] == mp4cop_pkg::TYPE_STCO)
                     || (recent_next[31:0] == mp4cop_pkg::TYPE_CO64);
        match_ok      = (cur_pos >= 32'd7)
                     && (({1'b0, cur_pos} + 33'd1) < {1'b0, len_reg})
                     && ({1'b0, cur_pos} >= ({1'b0, cur_atom_end} + 33'd4))
                     && type_hit;

        if (err_reg == mp4cop_pkg::ERR_NONE && cur_pos == mp4cop_pkg::CMOV_POSITION
            && recent_next[31:0] == mp4cop_pkg::TYPE_CMOV)
        begin
            err_next  = mp4cop_pkg::ERR_COMPRESSED;
            mode_next = mp4cop_pkg::MODE_SCAN;
        end

        if (err_next != mp4cop_pkg::ERR_NONE)
        begin
            pass = 1'b1;
        end
        else
        begin
            unique case (cur_mode)
                mp4cop_pkg::MODE_ENTRIES:
                begin
                    if (cnt_gather >= entry_width)
                    begin
                        complete  = 1'b1;
                        acc_next  = '0;
                        cnt_next  = '0;
                        left_next = cur_left - 32'd1;
                        if (left_next == '0)
                        begin
                            mode_next = mp4cop_pkg::MODE_SCAN;
                        end
                    end
                    else
                    begin
                        acc_next = acc_gather;
                        cnt_next = cnt_gather;
                    end
                end
                mp4cop_pkg::MODE_HEADER:
                begin
                    pass     = 1'b1;
                    cnt_next = cnt_dec;
                    if (cnt_dec == 4'd0)
                    begin
                        if (table_end > {5'd0, len_reg})
                        begin
                            err_next  = mp4cop_pkg::ERR_TABLE_OVER;
                            mode_next = mp4cop_pkg::MODE_SCAN;
                        end
                        else
                        begin
                            if (table_end > {5'd0, cur_atom_end})
                            begin
                                atom_end_next = table_end[31:0];
                            end
                            if (table_count == '0)
                            begin
                                mode_next = mp4cop_pkg::MODE_SCAN;
                            end
                            else
                            begin
                                left_next = table_count;
                                acc_next  = '0;
                                mode_next = mp4cop_pkg::MODE_ENTRIES;
                            end
                        end
                    end
                end
                default:
                begin
                    pass = 1'b1;
                    if (match_ok)
                    begin
                        if (box_size < mp4cop_pkg::MIN_ATOM_SIZE
                            || ({1'b0, atom_start} + {1'b0, box_size}) > {1'b0, len_reg})
                        begin
                            err_next = mp4cop_pkg::ERR_ATOM_OVER;
                        end
                        else
                        begin
                            atom_end_next = atom_start + box_size;
                            wide_next     = (recent_next[31:0] == mp4cop_pkg::TYPE_CO64);
                            cnt_next      = mp4cop_pkg::HEADER_BYTES;
                            mode_next     = mp4cop_pkg::MODE_HEADER;
                        end
                    end
                end
            endcase
        end
    end

    // Assemble the burst: flushed partial entry first, then this byte or a patched entry.
    always_comb
    begin
        flush_cnt = (first_byte && mode_reg == mp4cop_pkg::MODE_ENTRIES) ? cnt_reg : 4'd0;
        burst     = '0;
        sel       = '0;
        burst.err = err_next;
        if (complete)
        begin
            burst.count = entry_width;
            for (int i = 0; i < mp4cop_pkg::BURST_MAX; i++)
            begin
                sel = 3'(entry_width - 4'd1 - 4'(i));
                if (4'(i) < entry_width)
                begin
                    burst.bytes[i] = 8'(patched >> {sel, 3'b000});
                end
            end
        end
        else
        begin
            burst.count = flush_cnt + {3'd0, pass};
            for (int i = 0; i < mp4cop_pkg::BURST_MAX; i++)
            begin
                sel = 3'(flush_cnt - 4'd1 - 4'(i));
                if (4'(i) < flush_cnt)
                begin
                    burst.bytes[i] = 8'(acc_reg >> {sel, 3'b000});
                end
                else if (4'(i) == flush_cnt)
                begin
                    burst.bytes[i] = data_byte;
                end
            end
        end
    end

    assign push.valid = accept && (burst.count != 4'd0);
    assign push.burst = burst;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            len_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            recent_reg   <= '0;
            mode_reg     <= mp4cop_pkg::MODE_SCAN;
            wide_reg     <= 1'b0;
            atom_end_reg <= '0;
            left_reg     <= '0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            err_reg      <= mp4cop_pkg::ERR_NONE;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            recent_reg   <= recent_next;
            mode_reg     <= mode_next;
            wide_reg     <= wide_next;
            atom_end_reg <= atom_end_next;
            left_reg     <= left_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            err_reg      <= err_next;
        end
    end

endmodule

// File: rtl/mp4cop_burst_queue.sv
module mp4cop_burst_queue #(
    parameter int DEPTH = mp4cop_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mp4cop_pkg::push_t push,
    output logic              space,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              run_end,
    output logic [1:0]        error_code
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mp4cop_pkg::burst_t burst_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [2:0]       idx_reg, idx_next;

    mp4cop_pkg::burst_t head;
    logic               last_byte;
    logic               pop;

    assign head       = burst_mem[rd_ptr_reg];
    assign space      = fill_reg < CNT_W'(DEPTH);
    assign out_valid  = fill_reg != '0;
    assign out_byte   = head.bytes[idx_reg];
    assign last_byte  = {1'b0, idx_reg} == (head.count - 4'd1);
    assign run_end    = last_byte;
    assign error_code = head.err;
    assign pop        = out_valid && out_ready && last_byte;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (out_valid && out_ready)
        begin
            idx_next = last_byte ? 3'd0 : idx_reg + 3'd1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            burst_mem[wr_ptr_reg] <= push.burst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

// File: rtl/mp4cop_checker.sv
`include "mp4_chunk_offset_patcher_core_defines.svh"

module mp4cop_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        run_end,
    input logic [1:0]  error_code
);

    // hold a stalled output
    `MP4COP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(run_end) && $stable(error_code))

    // empty queue always has room
    `MP4COP_ASSERT_NOW(a_empty_ready, clk, rst_n, !out_valid, in_ready)

    // a burst continues on the next cycle with the same error code
    `MP4COP_ASSERT_NEXT(a_burst_err, clk, rst_n, out_valid && out_ready && !run_end,
        out_valid && error_code == $past(error_code))

    // a reported error never changes
    `MP4COP_ASSERT_NEXT(a_err_sticky, clk, rst_n,
        out_valid && out_ready && error_code != mp4cop_pkg::ERR_NONE,
        !out_valid || error_code == $past(error_code))

endmodule

bind mp4_chunk_offset_patcher_core mp4cop_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_end    (run_end),
    .error_code (error_code)
);

// File: test/mp4_chunk_offset_patcher_core_test.sv
`timescale 1ns / 100ps

module mp4_chunk_offset_patcher_core_test;
    import mp4cop_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_STALL = 300;
    localparam int PRINT_LIMIT = 50;
    localparam logic [31:0] TYPE_MOOV = 32'h6D6F6F76;

    typedef enum int {
        FAULT_COMPRESSED,
        FAULT_SHORT_ATOM,
        FAULT_ATOM_OVER,
        FAULT_TABLE_OVER
    } fault_t;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PATTERN
    } ready_style_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic [1:0] err;
    } result_byte_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        run_end;
    logic [1:0]  error_code;
    logic        cfg_write_en;
    logic [31:0] cfg_write_data;

    // predicted block state
    logic [31:0] offset_shift = '0;
    logic [31:0] stream_pos = '0;
    logic [63:0] window = '0;
    mode_t       scan_state = MODE_SCAN;
    logic        co64_table = 1'b0;
    logic [31:0] guard_end = '0;
    logic [31:0] entries_pending = '0;
    logic [63:0] entry_word = '0;
    logic [3:0]  entry_fill = '0;
    logic [1:0]  error_latch = ERR_NONE;

    result_byte_t expected_bytes [$];
    result_byte_t checked;
    logic [7:0]   stream_buf [$];

    int           fail_count = 0;
    int           cycles;
    int           burst_left;
    logic         gaps_on;
    logic         long_stall;
    ready_style_t ready_style;
    logic [15:0]  stall_pattern;
    logic [31:0]  current_len;

    mp4_chunk_offset_patcher_core uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .first_byte     (first_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_byte       (out_byte),
        .run_end        (run_end),
        .error_code     (error_code),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("mismatch %s: got %0h, want %0h, cycle %0d", field, got, want, cycles);
        fail_count++;
    endtask

    function automatic void predict_patch(input logic [7:0] b, input logic first);
        logic [7:0]   burst [$];
        logic [63:0]  p;
        logic [63:0]  len;
        logic [63:0]  sum;
        logic [63:0]  count;
        logic [63:0]  table_end;
        logic [63:0]  size;
        int           width;
        result_byte_t item;
        len = {32'd0, offset_shift};
        if (first)
        begin
            // flush a partly gathered entry unchanged
            if (scan_state == MODE_ENTRIES && entry_fill > 0)
                for (int k = int'(entry_fill) - 1; k >= 0; k--)
                    burst.push_back(entry_word[8*k +: 8]);
            stream_pos = '0;
            window = '0;
            scan_state = MODE_SCAN;
            co64_table = 1'b0;
            guard_end = '0;
            entries_pending = '0;
            entry_word = '0;
            entry_fill = '0;
        end
        p = {32'd0, stream_pos};
        window = {window[55:0], b};
        width = co64_table ? 8 : 4;
        if (error_latch == ERR_NONE && p == CMOV_POSITION && window[31:0] == TYPE_CMOV)
        begin
            error_latch = ERR_COMPRESSED;
            scan_state = MODE_SCAN;
        end
        if (error_latch != ERR_NONE)
            burst.push_back(b);
        else if (scan_state == MODE_ENTRIES)
        begin
            entry_word = {entry_word[55:0], b};
            entry_fill++;
            if (entry_fill >= width)
            begin
                sum = entry_word + len;
                if (!co64_table)
                    sum[63:32] = '0;
                for (int k = width - 1; k >= 0; k--)
                    burst.push_back(sum[8*k +: 8]);
                entry_word = '0;
                entry_fill = '0;
                entries_pending--;
                if (entries_pending == 0)
                    scan_state = MODE_SCAN;
            end
        end
        else if (scan_state == MODE_HEADER)
        begin
            burst.push_back(b);
            if (entry_fill > 0)
                entry_fill--;
            if (entry_fill == 0)
            begin
                count = {32'd0, window[31:0]};
                table_end = p + 64'd1 + count * 64'(width);
                if (table_end > len)
                begin
                    error_latch = ERR_TABLE_OVER;
                    scan_state = MODE_SCAN;
                end
                else
                begin
                    if (table_end > {32'd0, guard_end})
                        guard_end = table_end[31:0];
                    if (count == 0)
                        scan_state = MODE_SCAN;
                    else
                    begin
                        entries_pending = count[31:0];
                        entry_word = '0;
                        scan_state = MODE_ENTRIES;
                    end
                end
            end
        end
        else
        begin
            burst.push_back(b);
            if (p >= 64'd7 && p + 64'd1 < len && p >= {32'd0, guard_end} + 64'd4 &&
                (window[31:0] == TYPE_STCO || window[31:0] == TYPE_CO64))
            begin
                size = {32'd0, window[63:32]};
                if (size < MIN_ATOM_SIZE || p - 64'd7 + size > len)
                    error_latch = ERR_ATOM_OVER;
                else
                begin
                    guard_end = 32'(p - 64'd7 + size);
                    co64_table = (window[31:0] == TYPE_CO64);
                    entry_fill = HEADER_BYTES;
                    scan_state = MODE_HEADER;
                end
            end
        end
        if (stream_pos != '1)
            stream_pos++;
        foreach (burst[i])
        begin
            item.value = burst[i];
            item.last = (i == burst.size() - 1);
            item.err = error_latch;
            expected_bytes.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write_en)
                offset_shift = cfg_write_data;
            if (in_valid && in_ready)
                predict_patch(data_byte, first_byte);
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch("unexpected byte", out_byte, 8'h00);
                else
                begin
                    checked = expected_bytes.pop_front();
                    if (out_byte !== checked.value)
                        report_mismatch("out_byte", out_byte, checked.value);
                    if (run_end !== checked.last)
                        report_mismatch("run_end", {7'd0, run_end}, {7'd0, checked.last});
                    if (error_code !== checked.err)
                        report_mismatch("error_code", {6'd0, error_code}, {6'd0, checked.err});
                end
            end
        end
    end

    // receiver
    initial
    begin
        out_ready = 1'b0;
        stall_pattern = 16'b1011_0111_1100_1101;
        forever
        begin
            @(negedge clk);
            if (long_stall)
            begin
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(negedge clk);
                long_stall = 1'b0;
            end
            case (ready_style)
                READY_ALWAYS:
                    out_ready <= 1'b1;
                READY_RANDOM:
                    out_ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    out_ready <= stall_pattern[0];
                    stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                end
            endcase
        end
    end

    task automatic put_word(input logic [31:0] w);
        stream_buf.push_back(w[31:24]);
        stream_buf.push_back(w[23:16]);
        stream_buf.push_back(w[15:8]);
        stream_buf.push_back(w[7:0]);
    endtask

    task automatic put_table(input logic wide, input int count, input int pad,
                             input logic all_ones);
        int width;
        width = wide ? 8 : 4;
        put_word(32'(16 + count * width + pad));
        put_word(wide ? TYPE_CO64 : TYPE_STCO);
        put_word($urandom);
        put_word(32'(count));
        repeat (count * width / 4)
            put_word(all_ones ? 32'hFFFF_FFFF : $urandom);
        repeat (pad)
            stream_buf.push_back(8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first);
        in_valid <= 1'b1;
        data_byte <= b;
        first_byte <= first;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_range(input int lo, input int hi, input logic scatter);
        for (int i = lo; i < hi; i++)
            send_byte(stream_buf[i], i == 0 || (scatter && $urandom_range(0, 7) == 0));
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained;
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_index_length(input logic [31:0] value);
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        current_len = value;
    endtask

    task automatic test_pass_through;
        gaps_on = 1'b0;
        ready_style = READY_ALWAYS;
        write_index_length(32'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        in_valid <= 1'b0;
    endtask

    task automatic test_tables;
        // wrap at the entry width, narrow and wide entries
        gaps_on = 1'b1;
        ready_style = READY_RANDOM;
        write_index_length(32'hFFFF_FFFF);
        stream_buf.delete();
        put_table(1'b0, 1, 0, 1'b1);
        put_table(1'b1, 1, 0, 1'b1);
        send_range(0, stream_buf.size(), 1'b0);
    endtask

    task automatic test_new_atom_mid_entry;
        ready_style = READY_PATTERN;
        write_index_length(32'd64);
        stream_buf.delete();
        put_table(1'b1, 2, 0, 1'b0);
        send_range(0, 21, 1'b0);
        // empty table after the flush
        stream_buf.delete();
        put_table(1'b0, 0, 0, 1'b0);
        send_range(0, stream_buf.size(), 1'b0);
    endtask

    task automatic test_back_pressure;
        gaps_on = 1'b0;
        ready_style = READY_ALWAYS;
        write_index_length({1'b1, 31'($urandom)});
        stream_buf.delete();
        put_table(1'b0, 1, 0, 1'b0);
        long_stall = 1'b1;
        send_range(0, 12, 1'b0);
        // hold the sender until every result is out
        wait_drained();
        send_range(12, stream_buf.size(), 1'b0);
    endtask

    task automatic test_random_atoms;
        int sent;
        int hi;
        logic [31:0] len;
        sent = 0;
        while (sent < 16)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            ready_style = ready_style_t'($urandom_range(0, 2));
            stream_buf.delete();
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(3, 10))
                    stream_buf.push_back(8'($urandom));
            else
            begin
                if ($urandom_range(0, 1))
                begin
                    put_word($urandom);
                    put_word(TYPE_MOOV);
                end
                repeat ($urandom_range(1, 2))
                begin
                    repeat ($urandom_range(0, 5))
                        stream_buf.push_back(8'($urandom));
                    put_table($urandom_range(0, 1), $urandom_range(0, 4), $urandom_range(0, 3),
                              $urandom_range(0, 3) == 0);
                end
            end
            case ($urandom_range(0, 4))
                0: len = 32'(stream_buf.size());
                1: len = 32'(stream_buf.size() + $urandom_range(1, 1000));
                2: len = 32'hFFFF_FFFF;
                3: len = {1'b1, 31'($urandom)};
                default: len = 32'd0;
            endcase
            if ($urandom_range(0, 1) || (current_len != 0 && current_len < stream_buf.size()))
                write_index_length(len);
            hi = stream_buf.size();
            if ($urandom_range(0, 3) == 0)
                hi = $urandom_range(1, stream_buf.size());
            if ($urandom_range(0, 4) == 0 && hi > 2)
            begin
                send_range(0, hi / 2, 1'b0);
                wait_drained();
                send_range(hi / 2, hi, 1'b0);
            end
            else
                send_range(0, hi, stream_buf.size() < 11);
            sent += hi;
        end
    endtask

    task automatic test_sticky_error;
        fault_t fault;
        fault = fault_t'($urandom_range(0, 3));
        gaps_on = 1'b1;
        ready_style = READY_RANDOM;
        stream_buf.delete();
        put_word(32'd40);
        put_word(TYPE_MOOV);
        case (fault)
            FAULT_COMPRESSED:
            begin
                write_index_length(32'd64);
                put_word(32'd32);
                put_word(TYPE_CMOV);
                put_table(1'b0, 1, 0, 1'b0);
            end
            FAULT_SHORT_ATOM:
            begin
                write_index_length(32'd64);
                put_word(32'd12);
                put_word(TYPE_STCO);
                put_word(32'd0);
                put_word(32'd1);
                put_word($urandom);
            end
            FAULT_ATOM_OVER:
            begin
                write_index_length(32'd40);
                put_table(1'b0, 6, 0, 1'b0);
            end
            default:
            begin
                write_index_length(32'd48);
                put_word(32'd24);
                put_word(TYPE_STCO);
                put_word(32'd0);
                put_word(32'd1000);
                put_word($urandom);
            end
        endcase
        send_range(0, stream_buf.size(), 1'b0);
        // a new atom must not clear the error
        stream_buf.delete();
        put_table(1'b1, 1, 0, 1'b0);
        send_range(0, stream_buf.size(), 1'b0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        first_byte = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 32'd0;
        gaps_on = 1'b0;
        long_stall = 1'b0;
        ready_style = READY_ALWAYS;
        burst_left = 0;
        current_len = 32'd0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pass_through();
        test_tables();
        test_new_atom_mid_entry();
        test_back_pressure();
        test_random_atoms();
        test_sticky_error();

        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
